// ===== src/z80_branch_target_classifier_defines.svh =====
// Assertion macros used by the branch target classifier checker
`ifndef Z80_BRANCH_TARGET_CLASSIFIER_DEFINES_SVH
`define Z80_BRANCH_TARGET_CLASSIFIER_DEFINES_SVH

// check on every rising clk_i edge, skip while rst_ni is low
`define Z80BTC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// check on every rising clk_i edge, including during reset
`define Z80BTC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== src/z80btc_pkg.sv =====
// Types and opcode constants for the Z80 branch target classifier
`default_nettype none

package z80btc_pkg;

  typedef struct packed {
    logic [7:0]  opcode;
    logic        ed_prefix;
    logic [1:0]  index_prefix;
    logic [15:0] opcode_addr;
    logic [7:0]  operand_lo;
    logic [7:0]  operand_hi;
    logic [7:0]  flag_reg;
    logic [7:0]  reg_b;
    logic [15:0] reg_hl;
    logic [15:0] reg_ix;
    logic [15:0] reg_iy;
    logic [15:0] stack_word;
  } z80btc_in_t;

  typedef struct packed {
    logic [15:0] target;
    logic        is_branch;
    logic        target_indirect;
    logic        is_loop;
    logic        is_call;
    logic        is_block;
  } z80btc_out_t;

  // index prefix codes
  localparam logic [1:0] IDX_IX = 2'd1;
  localparam logic [1:0] IDX_IY = 2'd2;

  // condition codes (bits 5:4 of the opcode)
  localparam logic [1:0] CC_Z  = 2'd0;
  localparam logic [1:0] CC_C  = 2'd1;
  localparam logic [1:0] CC_PV = 2'd2;
  localparam logic [1:0] CC_S  = 2'd3;

  // F register bit positions
  localparam int unsigned FLAG_S_BIT  = 7;
  localparam int unsigned FLAG_Z_BIT  = 6;
  localparam int unsigned FLAG_PV_BIT = 2;
  localparam int unsigned FLAG_C_BIT  = 0;

  // opcodes and opcode patterns
  localparam logic [7:0] OP_HALT      = 8'h76;
  localparam logic [7:0] ED_BLK_MASK  = 8'hF4;
  localparam logic [7:0] ED_BLK_VAL   = 8'hB0;
  localparam logic [7:0] GRP_MASK     = 8'hC7;
  localparam logic [7:0] ED_RET_VAL   = 8'h45;
  localparam logic [7:0] OP_RET       = 8'hC9;
  localparam logic [7:0] OP_JP        = 8'hC3;
  localparam logic [7:0] OP_CALL      = 8'hCD;
  localparam logic [7:0] CC_GRP_MASK  = 8'hC1;
  localparam logic [7:0] CC_GRP_VAL   = 8'hC0;
  localparam logic [7:0] OP_RET_CC    = 8'hC0;
  localparam logic [7:0] OP_CALL_CC   = 8'hC4;
  localparam logic [7:0] OP_JP_CC     = 8'hC2;
  localparam logic [7:0] OP_JP_IND    = 8'hE9;
  localparam logic [7:0] OP_RST       = 8'hC7;
  localparam logic [7:0] RST_MASK     = 8'h38;
  localparam logic [7:0] REL_GRP_VAL  = 8'h00;
  localparam logic [7:0] OP_NOP       = 8'h00;
  localparam logic [7:0] OP_EX_AF     = 8'h08;
  localparam logic [7:0] OP_DJNZ      = 8'h10;
  localparam logic [7:0] OP_JR        = 8'h18;

  localparam logic [15:0] REL_OFFSET  = 16'd2;
  localparam logic [7:0]  DJNZ_LAST_B = 8'd1;

endpackage

`default_nettype wire

// ===== src/z80btc_if.sv =====
// Valid/ready channel interfaces for classifier requests and results
`default_nettype none

interface z80btc_req_if;
  import z80btc_pkg::*;

  logic       valid;
  logic       ready;
  z80btc_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface z80btc_rsp_if;
  import z80btc_pkg::*;

  logic        valid;
  logic        ready;
  z80btc_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== src/z80_branch_target_classifier.sv =====
// Z80 branch target classifier: registered decode of one instruction per cycle
// Each accepted instruction yields one result, and a new
// instruction can be accepted every cycle. The request is captured in an input
// register, decoded by a short combinational path (opcode compare, condition
// select and a three-term 16-bit add for relative targets) and held in a result
// register until the consumer takes it. in_i.ready follows the free slots of
// those two registers, so a stalled consumer blocks new requests only once
// both are full. No state is kept between instructions.
`default_nettype none

module z80_branch_target_classifier (
  input  wire             clk_i,
  input  wire             rst_ni,
  z80btc_req_if.sink      in_i,
  z80btc_rsp_if.source    out_o
);
  import z80btc_pkg::*;

  logic        s1_valid_q;
  z80btc_in_t  s1_data_q;
  logic        out_valid_q;
  z80btc_out_t out_data_q;
  logic        s1_ready;
  logic        cond_flag;
  logic        cond_ok;
  logic        jr_cond_ok;
  logic [15:0] rel_target;
  logic [15:0] base_reg;
  logic [15:0] abs_target;
  z80btc_out_t res_d;

  assign s1_ready   = !out_valid_q || out_o.ready;
  assign in_i.ready = !s1_valid_q || s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (s1_ready) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_data_q <= in_i.data;
    end
    if (s1_valid_q && s1_ready) begin
      out_data_q <= res_d;
    end
  end

  // select flag by condition code, compare against the sense bit
  always_comb begin
    unique case (s1_data_q.opcode[5:4])
      CC_Z:    cond_flag = s1_data_q.flag_reg[FLAG_Z_BIT];
      CC_C:    cond_flag = s1_data_q.flag_reg[FLAG_C_BIT];
      CC_PV:   cond_flag = s1_data_q.flag_reg[FLAG_PV_BIT];
      CC_S:    cond_flag = s1_data_q.flag_reg[FLAG_S_BIT];
      default: cond_flag = 1'b0;
    endcase
  end

  assign cond_ok    = (cond_flag == s1_data_q.opcode[3]);
  // jr cc tests Z or C only, chosen by bit 4
  assign jr_cond_ok = ((s1_data_q.opcode[4] ? s1_data_q.flag_reg[FLAG_C_BIT]
                                            : s1_data_q.flag_reg[FLAG_Z_BIT])
                       == s1_data_q.opcode[3]);
  assign abs_target = {s1_data_q.operand_hi, s1_data_q.operand_lo};
  assign rel_target = s1_data_q.opcode_addr + REL_OFFSET
                    + {{8{s1_data_q.operand_lo[7]}}, s1_data_q.operand_lo};

  always_comb begin
    unique case (s1_data_q.index_prefix)
      IDX_IX:  base_reg = s1_data_q.reg_ix;
      IDX_IY:  base_reg = s1_data_q.reg_iy;
      default: base_reg = s1_data_q.reg_hl;
    endcase
  end

  always_comb begin
    logic [7:0] op;
    op    = s1_data_q.opcode;
    res_d = '0;
    priority if (op == OP_HALT) begin
      res_d.is_block = 1'b1;
    end else if (s1_data_q.ed_prefix) begin
      priority if ((op & ED_BLK_MASK) == ED_BLK_VAL) begin
        res_d.is_block = 1'b1;
      end else if ((op & GRP_MASK) == ED_RET_VAL) begin
        res_d.target          = s1_data_q.stack_word;
        res_d.is_branch       = 1'b1;
        res_d.target_indirect = 1'b1;
      end else begin
        res_d = '0;
      end
    end else if (op == OP_RET) begin
      res_d.target          = s1_data_q.stack_word;
      res_d.is_branch       = 1'b1;
      res_d.target_indirect = 1'b1;
    end else if (op == OP_JP) begin
      res_d.target    = abs_target;
      res_d.is_branch = 1'b1;
    end else if (op == OP_CALL) begin
      res_d.target    = abs_target;
      res_d.is_branch = 1'b1;
      res_d.is_call   = 1'b1;
    end else if ((op & CC_GRP_MASK) == CC_GRP_VAL) begin
      priority if (cond_ok && (op & GRP_MASK) == OP_RET_CC) begin
        res_d.target          = s1_data_q.stack_word;
        res_d.is_branch       = 1'b1;
        res_d.target_indirect = 1'b1;
      end else if (cond_ok && (op & GRP_MASK) == OP_CALL_CC) begin
        res_d.target    = abs_target;
        res_d.is_branch = 1'b1;
        res_d.is_call   = 1'b1;
      end else if (cond_ok && (op & GRP_MASK) == OP_JP_CC) begin
        res_d.target    = abs_target;
        res_d.is_branch = 1'b1;
        res_d.is_loop   = 1'b1;
      end else begin
        res_d = '0;
      end
    end else if (op == OP_JP_IND) begin
      res_d.target          = base_reg;
      res_d.is_branch       = 1'b1;
      res_d.target_indirect = 1'b1;
    end else if ((op & GRP_MASK) == OP_RST) begin
      res_d.target    = {8'h00, op & RST_MASK};
      res_d.is_branch = 1'b1;
      res_d.is_call   = 1'b1;
    end else if ((op & GRP_MASK) == REL_GRP_VAL && op != OP_NOP && op != OP_EX_AF) begin
      priority if (op == OP_JR) begin
        res_d.target    = rel_target;
        res_d.is_branch = 1'b1;
      end else if (op == OP_DJNZ) begin
        if (s1_data_q.reg_b != DJNZ_LAST_B) begin
          res_d.target    = rel_target;
          res_d.is_branch = 1'b1;
          res_d.is_loop   = 1'b1;
        end
      end else if (jr_cond_ok) begin
        res_d.target    = rel_target;
        res_d.is_branch = 1'b1;
        res_d.is_loop   = 1'b1;
      end else begin
        res_d = '0;
      end
    end else begin
      res_d = '0;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

endmodule

`default_nettype wire

// ===== src/z80btc_checker.sv =====
// Port-level assertion checker for the branch target classifier, with its bind
`default_nettype none

`include "z80_branch_target_classifier_defines.svh"

module z80btc_checker (
  input wire                     clk_i,
  input wire                     rst_ni,
  input wire                     out_valid_i,
  input wire                     out_ready_i,
  input z80btc_pkg::z80btc_out_t out_data_i
);
  import z80btc_pkg::*;

  `Z80BTC_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i, "result dropped before transfer")
  `Z80BTC_ASSERT(a_no_branch_zero, out_valid_i && !out_data_i.is_branch |-> out_data_i.target == 16'h0000, "nonzero target without branch")
  `Z80BTC_ASSERT(a_kind_needs_branch, out_valid_i && (out_data_i.is_loop || out_data_i.is_call || out_data_i.target_indirect) |-> out_data_i.is_branch, "branch kind flagged without branch")
  `Z80BTC_ASSERT_ALWAYS(a_block_not_branch, out_valid_i && out_data_i.is_block |-> !out_data_i.is_branch, "block instruction reported as branch")

endmodule

bind z80_branch_target_classifier z80btc_checker u_z80btc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);

`default_nettype wire
